/* rtl/core/nbps_pkg.sv */
// Package: shared types, codes and sizes of the NAND page and block state checker.
package nbps_pkg;

	localparam int NUM_BLOCKS_DEF    = 1024;
	localparam int PAGES_PER_BLK_DEF = 64;

	localparam int CNT_W   = 7;
	localparam int EMPTY_W = 13;

	localparam logic [2:0] MODE_READ    = 3'd0;
	localparam logic [2:0] MODE_PROGRAM = 3'd1;
	localparam logic [2:0] MODE_ERASE   = 3'd2;
	localparam logic [2:0] MODE_INVAL   = 3'd3;
	localparam logic [2:0] MODE_QUERY   = 3'd4;
	localparam logic [2:0] MODE_MARK    = 3'd5;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_RANGE      = 3'd1;
	localparam logic [2:0] ST_BAD        = 3'd2;
	localparam logic [2:0] ST_PROGRAMMED = 3'd3;
	localparam logic [2:0] ST_ORDER      = 3'd4;
	localparam logic [2:0] ST_LIMIT      = 3'd5;

	localparam logic [1:0] HS_GOOD    = 2'd0;
	localparam logic [1:0] HS_FACTORY = 2'd1;
	localparam logic [1:0] HS_RUNTIME = 2'd2;

	localparam logic [1:0] PS_FREE    = 2'd0;
	localparam logic [1:0] PS_VALID   = 2'd1;
	localparam logic [1:0] PS_INVALID = 2'd2;

	typedef struct packed {
		logic [2:0]  mode;
		logic [11:0] block_index;
		logic [7:0]  page_index;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [1:0]  page_state;
		logic [1:0]  block_state;
		logic [15:0] wear_count;
		logic [6:0]  block_valid_pages;
		logic [6:0]  block_free_pages;
		logic [10:0] bad_block_total;
		logic [10:0] empty_block_total;
		logic [16:0] valid_page_total;
		logic [31:0] read_total;
		logic [31:0] write_total;
		logic [31:0] erase_total;
	} out_item_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic [11:0] blk;
		logic [7:0]  pg;
		logic        blk_ok;
		logic        pg_ok;
	} cmd_t;

	typedef struct packed {
		logic [1:0]       health;
		logic [15:0]      erase_cnt;
		logic [CNT_W-1:0] valid_cnt;
		logic [CNT_W-1:0] next_pg;
		logic [CNT_W-1:0] prog_cnt;
	} meta_t;

	typedef enum logic [1:0] {
		BS_CLEAR,
		BS_IDLE,
		BS_EXEC
	} back_state_t;

endpackage

/* rtl/core/nbps_front.sv */
// Front end: takes command beats, checks address range, queues them for the back end.
module nbps_front #(
	parameter int NUM_BLOCKS    = nbps_pkg::NUM_BLOCKS_DEF,
	parameter int PAGES_PER_BLK = nbps_pkg::PAGES_PER_BLK_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  nbps_pkg::in_item_t in_item,
	input  logic               busy,
	output logic               q_valid,
	output nbps_pkg::cmd_t     q_head,
	input  logic               q_pop
);

	nbps_pkg::cmd_t fifo_q [2];
	logic           wptr_q;
	logic           rptr_q;
	logic [1:0]     cnt_q;
	logic           push;
	nbps_pkg::cmd_t cmd_in;

	always_comb begin
		cmd_in.mode   = in_item.mode;
		cmd_in.blk    = in_item.block_index;
		cmd_in.pg     = in_item.page_index;
		cmd_in.blk_ok = {1'b0, in_item.block_index} < 13'(NUM_BLOCKS);
		cmd_in.pg_ok  = {1'b0, in_item.page_index} < 9'(PAGES_PER_BLK);
	end

	assign in_stall = cnt_q[1] | busy;
	assign push     = in_valid & ~in_stall;
	assign q_valid  = cnt_q != 2'd0;
	assign q_head   = fifo_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (q_pop) begin
				rptr_q <= ~rptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

endmodule

/* rtl/core/nbps_back.sv */
// Back end: block metadata memory, rule checks, update, chip totals and result register.
module nbps_back #(
	parameter int NUM_BLOCKS    = nbps_pkg::NUM_BLOCKS_DEF,
	parameter int PAGES_PER_BLK = nbps_pkg::PAGES_PER_BLK_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [15:0]         max_erase,
	output logic                busy,
	input  logic                q_valid,
	input  nbps_pkg::cmd_t      q_head,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_stall,
	output nbps_pkg::out_item_t out_item
);

	localparam int BIW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int PW  = PAGES_PER_BLK;
	localparam int CW  = nbps_pkg::CNT_W;
	localparam int EW  = nbps_pkg::EMPTY_W;

	logic [PW-1:0]  prog_mem [NUM_BLOCKS];
	logic [PW-1:0]  inv_mem  [NUM_BLOCKS];
	nbps_pkg::meta_t meta_mem [NUM_BLOCKS];

	nbps_pkg::back_state_t state_q, state_d;
	logic [BIW-1:0]  clr_q;
	nbps_pkg::cmd_t  cmd_s1;
	logic [PW-1:0]   prog_s2;
	logic [PW-1:0]   inv_s2;
	nbps_pkg::meta_t meta_s2;

	logic [10:0]   bad_q, bad_d;
	logic [EW-1:0] empty_q, empty_d, empty_t;
	logic [16:0]   vsum_q, vsum_d;
	logic [31:0]   rd_q, rd_d;
	logic [31:0]   wr_q, wr_d;
	logic [31:0]   er_q, er_d;

	logic                out_valid_q;
	nbps_pkg::out_item_t out_q, res;

	logic            can_load, exec_go, mem_we, mem_clr, rd_en;
	logic [BIW-1:0]  wr_addr;
	logic [PW-1:0]   bit_sel, prog_n, inv_n;
	nbps_pkg::meta_t meta_n;
	logic [2:0]      st;
	logic            page_mode;
	logic [15:0]     erase_inc;

	assign busy      = state_q == nbps_pkg::BS_CLEAR;
	assign can_load  = ~out_valid_q | ~out_stall;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		rd_en   = 1'b0;
		exec_go = 1'b0;
		mem_clr = 1'b0;
		unique case (state_q)
			nbps_pkg::BS_CLEAR: begin
				mem_clr = 1'b1;
				if (clr_q == BIW'(NUM_BLOCKS - 1)) begin
					state_d = nbps_pkg::BS_IDLE;
				end
			end
			nbps_pkg::BS_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					rd_en   = 1'b1;
					state_d = nbps_pkg::BS_EXEC;
				end
			end
			nbps_pkg::BS_EXEC: begin
				if (can_load) begin
					exec_go = 1'b1;
					state_d = nbps_pkg::BS_IDLE;
				end
			end
			default: state_d = nbps_pkg::BS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nbps_pkg::BS_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (mem_clr) begin
				clr_q <= clr_q + BIW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			cmd_s1 <= q_head;
		end
	end

	assign mem_we  = mem_clr | (exec_go & cmd_s1.blk_ok);
	assign wr_addr = mem_clr ? clr_q : cmd_s1.blk[BIW-1:0];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			prog_mem[wr_addr] <= mem_clr ? '0 : prog_n;
			inv_mem[wr_addr]  <= mem_clr ? '0 : inv_n;
			meta_mem[wr_addr] <= mem_clr ? '0 : meta_n;
		end
		if (rd_en) begin
			prog_s2 <= prog_mem[q_head.blk[BIW-1:0]];
			inv_s2  <= inv_mem[q_head.blk[BIW-1:0]];
			meta_s2 <= meta_mem[q_head.blk[BIW-1:0]];
		end
	end

	always_comb begin
		bit_sel   = PW'(1) << cmd_s1.pg;
		prog_n    = prog_s2;
		inv_n     = inv_s2;
		meta_n    = meta_s2;
		st        = nbps_pkg::ST_OK;
		bad_d     = bad_q;
		empty_d   = empty_q;
		empty_t   = empty_q;
		vsum_d    = vsum_q;
		rd_d      = rd_q;
		wr_d      = wr_q;
		er_d      = er_q;
		erase_inc = (meta_s2.erase_cnt != 16'hFFFF) ? meta_s2.erase_cnt + 16'd1 : 16'hFFFF;
		page_mode = cmd_s1.mode == nbps_pkg::MODE_READ || cmd_s1.mode == nbps_pkg::MODE_PROGRAM
			|| cmd_s1.mode == nbps_pkg::MODE_INVAL;

		priority if (!cmd_s1.blk_ok || (page_mode && !cmd_s1.pg_ok)) begin
			st = nbps_pkg::ST_RANGE;
		end else if (cmd_s1.mode <= nbps_pkg::MODE_INVAL && meta_s2.health != nbps_pkg::HS_GOOD) begin
			st = nbps_pkg::ST_BAD;
		end else begin
			unique case (cmd_s1.mode)
				nbps_pkg::MODE_READ: begin
					rd_d = (rd_q != 32'hFFFF_FFFF) ? rd_q + 32'd1 : rd_q;
				end
				nbps_pkg::MODE_PROGRAM: begin
					priority if ((prog_s2 & bit_sel) != '0) begin
						st = nbps_pkg::ST_PROGRAMMED;
					end else if (cmd_s1.pg < 8'(meta_s2.next_pg)) begin
						st = nbps_pkg::ST_ORDER;
					end else begin
						prog_n           = prog_s2 | bit_sel;
						meta_n.valid_cnt = meta_s2.valid_cnt + CW'(1);
						meta_n.prog_cnt  = meta_s2.prog_cnt + CW'(1);
						meta_n.next_pg   = CW'(cmd_s1.pg) + CW'(1);
						vsum_d = (vsum_q < 17'h1FFFF) ? vsum_q + 17'd1 : 17'h1FFFF;
						if (meta_s2.next_pg == '0) begin
							empty_d = (empty_q != '0) ? empty_q - EW'(1) : '0;
						end
						wr_d = (wr_q != 32'hFFFF_FFFF) ? wr_q + 32'd1 : wr_q;
					end
				end
				nbps_pkg::MODE_ERASE: begin
					prog_n           = '0;
					inv_n            = '0;
					meta_n.erase_cnt = erase_inc;
					meta_n.valid_cnt = '0;
					meta_n.prog_cnt  = '0;
					meta_n.next_pg   = '0;
					vsum_d = (vsum_q >= 17'(meta_s2.valid_cnt)) ?
						vsum_q - 17'(meta_s2.valid_cnt) : '0;
					if (meta_s2.next_pg != '0) begin
						empty_t = (empty_q < EW'(2047)) ? empty_q + EW'(1) : EW'(2047);
					end
					empty_d = empty_t;
					if (erase_inc >= max_erase) begin
						meta_n.health = nbps_pkg::HS_RUNTIME;
						bad_d   = (bad_q < 11'h7FF) ? bad_q + 11'd1 : 11'h7FF;
						empty_d = (empty_t != '0) ? empty_t - EW'(1) : '0;
						st      = nbps_pkg::ST_LIMIT;
					end else begin
						er_d = (er_q != 32'hFFFF_FFFF) ? er_q + 32'd1 : er_q;
					end
				end
				nbps_pkg::MODE_INVAL: begin
					if ((prog_s2 & bit_sel) != '0 && (inv_s2 & bit_sel) == '0) begin
						inv_n            = inv_s2 | bit_sel;
						meta_n.valid_cnt = (meta_s2.valid_cnt != '0) ?
							meta_s2.valid_cnt - CW'(1) : '0;
						vsum_d = (vsum_q != '0) ? vsum_q - 17'd1 : '0;
					end
				end
				nbps_pkg::MODE_MARK: begin
					if (meta_s2.health != nbps_pkg::HS_GOOD) begin
						st = nbps_pkg::ST_BAD;
					end else begin
						meta_n.health = nbps_pkg::HS_FACTORY;
						bad_d = (bad_q < 11'h7FF) ? bad_q + 11'd1 : 11'h7FF;
						if (meta_s2.next_pg == '0) begin
							empty_d = (empty_q != '0) ? empty_q - EW'(1) : '0;
						end
					end
				end
				default: begin
				end
			endcase
		end

		res.status            = st;
		res.page_state        = nbps_pkg::PS_FREE;
		res.block_state       = nbps_pkg::HS_RUNTIME;
		res.wear_count        = '0;
		res.block_valid_pages = '0;
		res.block_free_pages  = '0;
		if (cmd_s1.blk_ok) begin
			res.block_state       = meta_n.health;
			res.wear_count        = meta_n.erase_cnt;
			res.block_valid_pages = meta_n.valid_cnt;
			if (meta_n.health == nbps_pkg::HS_GOOD) begin
				res.block_free_pages = CW'(PW) - meta_n.prog_cnt;
			end
			if (cmd_s1.pg_ok && (prog_n & bit_sel) != '0) begin
				res.page_state = ((inv_n & bit_sel) != '0) ? nbps_pkg::PS_INVALID :
					nbps_pkg::PS_VALID;
			end
		end
		res.bad_block_total   = bad_d;
		res.empty_block_total = empty_d[10:0];
		res.valid_page_total  = vsum_d;
		res.read_total        = rd_d;
		res.write_total       = wr_d;
		res.erase_total       = er_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bad_q       <= '0;
			empty_q     <= EW'(NUM_BLOCKS);
			vsum_q      <= '0;
			rd_q        <= '0;
			wr_q        <= '0;
			er_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (exec_go) begin
				bad_q       <= bad_d;
				empty_q     <= empty_d;
				vsum_q      <= vsum_d;
				rd_q        <= rd_d;
				wr_q        <= wr_d;
				er_q        <= er_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exec_go) begin
			out_q <= res;
		end
	end

endmodule

/* rtl/core/nand_block_page_state_checker_unit.sv */
// Top level: NAND page and block state checker.
//
//  channel | direction | handshake           | beat
//  cmd     | in        | cmd_valid/cmd_stall | nbps_pkg::in_item_t
//  rsp     | out       | rsp_valid/rsp_stall | nbps_pkg::out_item_t
//  cfg     | in        | cfg_we              | erase limit, 16 bit
//
// The back end reads block metadata for a command, then checks it and writes back.
// A two-entry queue sits between front and back; the result register frees the back end.
// After reset a clearing pass writes all NUM_BLOCKS metadata rows;
// cmd_stall is high during it. rsp_stall holds the result and, once the queue fills,
// stalls the command side.
module nand_block_page_state_checker_unit #(
	parameter int NUM_BLOCKS    = nbps_pkg::NUM_BLOCKS_DEF,
	parameter int PAGES_PER_BLK = nbps_pkg::PAGES_PER_BLK_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  nbps_pkg::in_item_t  cmd,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output nbps_pkg::out_item_t rsp,
	input  logic                cfg_we,
	input  logic [15:0]         cfg_data
);

	logic [15:0]    max_erase_q;
	logic           busy;
	logic           q_valid;
	logic           q_pop;
	nbps_pkg::cmd_t q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_erase_q <= 16'd3000;
		end else if (cfg_we) begin
			max_erase_q <= cfg_data;
		end
	end

	nbps_front #(
		.NUM_BLOCKS   (NUM_BLOCKS),
		.PAGES_PER_BLK(PAGES_PER_BLK)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(cmd_valid),
		.in_stall(cmd_stall),
		.in_item (cmd),
		.busy    (busy),
		.q_valid (q_valid),
		.q_head  (q_head),
		.q_pop   (q_pop)
	);

	nbps_back #(
		.NUM_BLOCKS   (NUM_BLOCKS),
		.PAGES_PER_BLK(PAGES_PER_BLK)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.max_erase(max_erase_q),
		.busy     (busy),
		.q_valid  (q_valid),
		.q_head   (q_head),
		.q_pop    (q_pop),
		.out_valid(rsp_valid),
		.out_stall(rsp_stall),
		.out_item (rsp)
	);

endmodule
